// ----- design/utbd_pkg.sv -----
package utbd_pkg;

  // Sizing of the converter.
  localparam int NUMBER_WIDTH = 64;
  localparam int MAX_BASE     = 16;
  localparam int DIGIT_DEPTH  = 64;

  // The divider retires this many dividend bits per cycle.
  localparam int STEP_BITS = 8;
  localparam int CHUNKS    = (NUMBER_WIDTH + STEP_BITS - 1) / STEP_BITS;
  localparam int VAL_W     = CHUNKS * STEP_BITS;
  localparam int CHUNK_CW  = $clog2(CHUNKS + 1);

  // Fixed field widths of the ports.
  localparam int IN_W      = 64;
  localparam int CFG_W     = 64;
  localparam int CODE_W    = 8;
  localparam int COUNT_W   = 7;
  localparam int RADIX_W   = 5;
  localparam int DIGIT_W   = 4;
  localparam int ALPHA_N   = 16;
  localparam int ALPHA_HALF = ALPHA_N / 2;

  localparam int ADDR_W = $clog2(DIGIT_DEPTH);
  localparam int CNT_W  = $clog2(DIGIT_DEPTH + 1);

  // Register indexes of the configuration port.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_LEN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_HIGH = 2'd2;

  // Character codes that an alphabet may not contain.
  localparam logic [CODE_W-1:0] CHAR_NUL   = 8'h00;
  localparam logic [CODE_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CODE_W-1:0] CHAR_MINUS = 8'h2D;

  typedef logic [CODE_W-1:0] code_t;
  typedef code_t alphabet_t [ALPHA_N];

endpackage

// ----- design/unsigned_to_base_digits.sv -----
// Sequencing: an invalid alphabet passes through the ERR state, and its error word is loaded
// into the output register once that has room. A valid number is divided one digit at a time
// in the shared divider, then characters leave one per cycle while the output is not stalled.
// One input word is in flight at a time.
// Reset (rst_n low, synchronous) clears the sequencer, the output valid flag and the
// configuration registers; the digit store is not cleared and needs no clearing pass.
module unsigned_to_base_digits
  import utbd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // Configuration write port.
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  // Input channel.
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [IN_W-1:0]      in_number,
  // Result channel.
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [CODE_W-1:0]    out_char_code,
  output logic                 out_is_last,
  output logic                 out_base_error,
  output logic [COUNT_W-1:0]   out_char_count
);

  // The sequencer has four phases. IDLE waits for a word. ERR delivers the single error
  // word when the alphabet fails validation. DIV runs the shared divider: each cycle it
  // folds one byte of the value into the running remainder, and after its CHUNKS steps the
  // value register holds the quotient and the remainder is the next digit, least
  // significant first. EMIT reads the digit store backwards and maps digits through the
  // alphabet, so characters leave most significant first.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ERR,
    ST_DIV,
    ST_EMIT
  } state_t;

  state_t                state_r, state_nxt;
  logic [RADIX_W-1:0]    base_len_r;
  logic [CFG_W-1:0]      alpha_lo_r;
  logic [CFG_W-1:0]      alpha_hi_r;

  logic [VAL_W-1:0]      val_r, val_nxt;
  logic [DIGIT_W-1:0]    rem_r, rem_nxt;
  logic [CHUNK_CW-1:0]   chunk_r, chunk_nxt;
  logic                  qnz_r, qnz_nxt;
  logic [CNT_W-1:0]      n_r, n_nxt;
  logic [CNT_W-1:0]      issue_r, issue_nxt;
  logic [CNT_W-1:0]      k_r, k_nxt;
  logic                  rd_pend_r, rd_pend_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [CODE_W-1:0]     out_char_r, out_char_nxt;
  logic                  out_last_r, out_last_nxt;
  logic                  out_err_r, out_err_nxt;
  logic [COUNT_W-1:0]    out_cnt_r, out_cnt_nxt;

  alphabet_t             alpha;
  logic                  alpha_ok;
  logic [STEP_BITS-1:0]  qbyte;
  logic [DIGIT_W-1:0]    step_rem;
  logic                  can_load;
  logic                  load;
  logic                  rd_issue;
  logic                  ram_we;
  logic [ADDR_W-1:0]     rd_addr;
  logic [DIGIT_W-1:0]    rd_digit;
  logic                  accept;

  // Unpack the two configuration words into one code per digit.
  always_comb begin
    for (int k = 0; k < ALPHA_N; k++) begin
      if (k < ALPHA_HALF) begin
        alpha[k] = alpha_lo_r[CODE_W*k +: CODE_W];
      end else begin
        alpha[k] = alpha_hi_r[CODE_W*(k-ALPHA_HALF) +: CODE_W];
      end
    end
  end

  // Alphabet check: the radix must lie in range, and the codes in use must be
  // free of zero, plus and minus, and all distinct. The pairwise compares are
  // independent of each other and reduce through one OR.
  always_comb begin
    logic bad;
    logic in_use;
    bad = (base_len_r < RADIX_W'(2)) || (base_len_r > RADIX_W'(MAX_BASE));
    for (int k = 0; k < ALPHA_N; k++) begin
      in_use = RADIX_W'(k) < base_len_r;
      if (in_use && (alpha[k] == CHAR_NUL || alpha[k] == CHAR_PLUS ||
                     alpha[k] == CHAR_MINUS)) begin
        bad = 1'b1;
      end
      for (int j = 0; j < k; j++) begin
        if (in_use && alpha[j] == alpha[k]) begin
          bad = 1'b1;
        end
      end
    end
    alpha_ok = !bad;
  end

  // One divider step: long division of the top byte of the value by the radix,
  // one bit at a time. The remainder stays below the radix, so it fits in a digit.
  always_comb begin
    logic [RADIX_W-1:0] t;
    logic [DIGIT_W-1:0] r;
    r = rem_r;
    for (int i = STEP_BITS - 1; i >= 0; i--) begin
      t = {r, val_r[VAL_W-STEP_BITS+i]};
      if (t >= base_len_r) begin
        t = t - base_len_r;
        qbyte[i] = 1'b1;
      end else begin
        qbyte[i] = 1'b0;
      end
      r = t[DIGIT_W-1:0];
    end
    step_rem = r;
  end

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // The output register can take a new word when it is empty or being drained.
  assign can_load = !out_valid_r || !out_stall;

  // In EMIT a word is loaded when store data is waiting and the output has room.
  // A new read goes out when nothing is pending or the pending data is being used.
  assign load     = (state_r == ST_EMIT) && rd_pend_r && can_load;
  assign rd_issue = (state_r == ST_EMIT) && (issue_r < n_r) && (!rd_pend_r || load);
  assign rd_addr  = ADDR_W'(n_r - issue_r - CNT_W'(1));
  assign ram_we   = (state_r == ST_DIV) && (chunk_r == CHUNK_CW'(CHUNKS - 1));

  utbd_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (DIGIT_DEPTH)
  ) u_digit_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (n_r[ADDR_W-1:0]),
    .wr_data (step_rem),
    .rd_en   (rd_issue),
    .rd_addr (rd_addr),
    .rd_data (rd_digit)
  );

  always_comb begin
    state_nxt     = state_r;
    val_nxt       = val_r;
    rem_nxt       = rem_r;
    chunk_nxt     = chunk_r;
    qnz_nxt       = qnz_r;
    n_nxt         = n_r;
    issue_nxt     = issue_r;
    k_nxt         = k_r;
    rd_pend_nxt   = rd_pend_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_err_nxt   = out_err_r;
    out_cnt_nxt   = out_cnt_r;

    if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (alpha_ok) begin
            val_nxt   = VAL_W'(in_number[NUMBER_WIDTH-1:0]);
            rem_nxt   = '0;
            chunk_nxt = '0;
            qnz_nxt   = 1'b0;
            n_nxt     = '0;
            state_nxt = ST_DIV;
          end else begin
            state_nxt = ST_ERR;
          end
        end
      end

      ST_ERR: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = '0;
          out_last_nxt  = 1'b1;
          out_err_nxt   = 1'b1;
          out_cnt_nxt   = '0;
          state_nxt     = ST_IDLE;
        end
      end

      ST_DIV: begin
        // The quotient bytes shift in at the bottom as the dividend shifts out at the top.
        val_nxt = (val_r << STEP_BITS) | VAL_W'(qbyte);
        rem_nxt = step_rem;
        qnz_nxt = qnz_r || (qbyte != '0);
        if (chunk_r == CHUNK_CW'(CHUNKS - 1)) begin
          // Digit complete: it is written to the store this cycle.
          chunk_nxt = '0;
          rem_nxt   = '0;
          qnz_nxt   = 1'b0;
          n_nxt     = n_r + CNT_W'(1);
          // Stop on a zero quotient, or when the store is full (only the least
          // significant digits are then kept).
          if (!(qnz_r || (qbyte != '0)) || (n_r == CNT_W'(DIGIT_DEPTH - 1))) begin
            issue_nxt   = '0;
            k_nxt       = '0;
            rd_pend_nxt = 1'b0;
            state_nxt   = ST_EMIT;
          end
        end else begin
          chunk_nxt = chunk_r + CHUNK_CW'(1);
        end
      end

      ST_EMIT: begin
        if (rd_issue) begin
          issue_nxt   = issue_r + CNT_W'(1);
          rd_pend_nxt = 1'b1;
        end else if (load) begin
          rd_pend_nxt = 1'b0;
        end
        if (load) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = alpha[rd_digit];
          out_last_nxt  = (k_r + CNT_W'(1) == n_r);
          out_err_nxt   = 1'b0;
          out_cnt_nxt   = COUNT_W'(k_r + CNT_W'(1));
          k_nxt         = k_r + CNT_W'(1);
          if (k_r + CNT_W'(1) == n_r) begin
            state_nxt = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      base_len_r  <= '0;
      alpha_lo_r  <= '0;
      alpha_hi_r  <= '0;
      chunk_r     <= '0;
      qnz_r       <= 1'b0;
      n_r         <= '0;
      issue_r     <= '0;
      k_r         <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      chunk_r     <= chunk_nxt;
      qnz_r       <= qnz_nxt;
      n_r         <= n_nxt;
      issue_r     <= issue_nxt;
      k_r         <= k_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_BASE_LEN:   base_len_r <= cfg_wdata[RADIX_W-1:0];
          CFG_ALPHA_LOW:  alpha_lo_r <= cfg_wdata;
          CFG_ALPHA_HIGH: alpha_hi_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
    // Datapath registers carry no reset.
    val_r      <= val_nxt;
    rem_r      <= rem_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    out_err_r  <= out_err_nxt;
    out_cnt_r  <= out_cnt_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_char_code  = out_char_r;
  assign out_is_last    = out_last_r;
  assign out_base_error = out_err_r;
  assign out_char_count = out_cnt_r;

endmodule

// ----- design/utbd_ram.sv -----
module utbd_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
